// ----- design/epid_pkg.sv -----
// Shared types, codes and constants of the two-motor encoder PID speed controller.
package epid_pkg;

	// stream and configuration port widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DIVISOR   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 3'd4;

	// datapath operation codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
	localparam logic [OP_W-1:0] OP_MAG    = 4'd2;
	localparam logic [OP_W-1:0] OP_CMP    = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
	localparam logic [OP_W-1:0] OP_SPD    = 4'd5;
	localparam logic [OP_W-1:0] OP_ERR    = 4'd6;
	localparam logic [OP_W-1:0] OP_MI     = 4'd7;
	localparam logic [OP_W-1:0] OP_IA     = 4'd8;
	localparam logic [OP_W-1:0] OP_MP     = 4'd9;
	localparam logic [OP_W-1:0] OP_MG     = 4'd10;
	localparam logic [OP_W-1:0] OP_MD     = 4'd11;
	localparam logic [OP_W-1:0] OP_AD     = 4'd12;
	localparam logic [OP_W-1:0] OP_DRV    = 4'd13;
	localparam logic [OP_W-1:0] OP_CMD    = 4'd14;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd15;

	// count direction codes (two's complement +1, -1, 0)
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	// arithmetic widths and constants
	localparam int MB       = 17;   // second multiplier operand
	localparam int ACC_W    = 24;   // Q16.8 state
	localparam int AW       = 34;   // drive sum before saturation
	localparam int ERR_W    = 9;
	localparam int DER_W    = 10;
	localparam int QUO_BITS = 8;
	localparam logic signed [MB-1:0]    SPEED_SCALE = 17'sd6000;
	localparam logic signed [7:0]       FAST_SPEED  = 8'sd15;
	localparam logic signed [ERR_W-1:0] ERR_FLOOR   = -9'sd10;
	localparam logic signed [16:0]      CMD_MAX     = 17'sd100;
	localparam logic [6:0]              SPD_MAX     = 7'd127;
	// 255/100 as 10445/4096, exact after flooring for magnitudes up to 100
	localparam logic [13:0]             DUTY_MUL    = 14'd10445;
	localparam int                      DUTY_SHIFT  = 12;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            motor;
	} cmd_t;

	typedef struct packed {
		logic fire;
	} status_t;

endpackage

// ----- design/epid_ctrl.sv -----
// Sequencer of the speed controller: handshakes and the per-motor step order.
module epid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	input  logic             s_kind,
	output logic             s_ready,
	output logic             m_valid,
	input  logic             m_ready,
	input  epid_pkg::status_t st,
	output epid_pkg::cmd_t    cmd
);
	import epid_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAG  = 4'd1;
	localparam logic [3:0] ST_CMP  = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_SPD  = 4'd4;
	localparam logic [3:0] ST_ERR  = 4'd5;
	localparam logic [3:0] ST_MI   = 4'd6;
	localparam logic [3:0] ST_IA   = 4'd7;
	localparam logic [3:0] ST_MP   = 4'd8;
	localparam logic [3:0] ST_MG   = 4'd9;
	localparam logic [3:0] ST_MD   = 4'd10;
	localparam logic [3:0] ST_AD   = 4'd11;
	localparam logic [3:0] ST_DRV  = 4'd12;
	localparam logic [3:0] ST_CMD  = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	logic [3:0] state_q, state_nx;
	logic       motor_q;
	logic [2:0] bit_q;
	logic       m_valid_q;
	logic       load;

	assign s_ready   = (state_q == ST_IDLE);
	assign m_valid   = m_valid_q;
	assign load      = (state_q == ST_DONE) && (!m_valid_q || m_ready);

	always_comb begin
		state_nx  = state_q;
		cmd.op    = OP_NONE;
		cmd.motor = motor_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.op   = OP_ACCEPT;
					state_nx = (s_kind && st.fire) ? ST_MAG : ST_DONE;
				end
			end
			ST_MAG: begin cmd.op = OP_MAG; state_nx = ST_CMP; end
			ST_CMP: begin cmd.op = OP_CMP; state_nx = ST_DIV; end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (bit_q == 3'(QUO_BITS - 1)) state_nx = ST_SPD;
			end
			ST_SPD: begin cmd.op = OP_SPD; state_nx = ST_ERR; end
			ST_ERR: begin cmd.op = OP_ERR; state_nx = ST_MI; end
			ST_MI:  begin cmd.op = OP_MI;  state_nx = ST_IA; end
			ST_IA:  begin cmd.op = OP_IA;  state_nx = ST_MP; end
			ST_MP:  begin cmd.op = OP_MP;  state_nx = ST_MG; end
			ST_MG:  begin cmd.op = OP_MG;  state_nx = ST_MD; end
			ST_MD:  begin cmd.op = OP_MD;  state_nx = ST_AD; end
			ST_AD:  begin cmd.op = OP_AD;  state_nx = ST_DRV; end
			ST_DRV: begin cmd.op = OP_DRV; state_nx = ST_CMD; end
			ST_CMD: begin
				cmd.op   = OP_CMD;
				state_nx = motor_q ? ST_DONE : ST_MAG;
			end
			ST_DONE: begin
				if (load) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			motor_q   <= 1'b0;
			bit_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV) bit_q <= bit_q + 3'd1;
			// second motor follows the first
			if (state_q == ST_CMD) motor_q <= ~motor_q;
			if (load) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> (state_q == ST_IDLE))
		else $error("result loaded outside the done step");
	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (bit_q == 3'd0))
		else $error("divide step counter left running");
	a_motor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !motor_q)
		else $error("motor index not back to left at idle");
	a_fire_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready && s_kind && st.fire) |=> (state_q == ST_MAG))
		else $error("update tick did not start the control step");

endmodule

// ----- design/epid_dp.sv -----
// Datapath of the speed controller: encoder counters, shared multiplier, divider, PID state.
module epid_dp #(
	parameter int TICKS_PER_UPDATE = 4,
	parameter int COUNT_BITS       = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  epid_pkg::cmd_t                      cmd,
	output epid_pkg::status_t                   st,
	input  logic [epid_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic                                in_kind,
	input  logic                                cfg_we,
	input  logic [epid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [epid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic [epid_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic                                out_updated
);
	import epid_pkg::*;

	localparam int CB   = COUNT_BITS;
	localparam int MAGW = CB + 12;
	localparam int MA   = (CB + 1 > ACC_W) ? CB + 1 : ACC_W;
	localparam int PW   = MA + MB;
	localparam int CW   = (MAGW > 23) ? MAGW : 23;
	localparam int TW   = (TICKS_PER_UPDATE > 1) ? $clog2(TICKS_PER_UPDATE) : 1;

	// configuration
	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;
	logic [15:0]        divisor_q, period_q;

	// per-motor state
	logic signed [CB-1:0]       count_q    [2];
	logic [1:0]                 dir_q      [2];
	logic [1:0]                 last_a_q;
	logic signed [7:0]          speed_q    [2];
	logic signed [ERR_W-1:0]    last_err_q [2];
	logic signed [ACC_W-1:0]    integ_q    [2];
	logic signed [ACC_W-1:0]    drive_q    [2];
	logic [7:0]                 fwd_q      [2];
	logic [7:0]                 rev_q      [2];
	logic [TW-1:0]              tick_q;

	// working registers
	logic signed [7:0]       tgt_q [2];
	logic                    upd_q;
	logic signed [PW-1:0]    mul_q;
	logic                    sgn_q;
	logic [CW-1:0]           rem_q, dsh_q;
	logic [QUO_BITS-1:0]     quo_q;
	logic                    ovf_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [AW-1:0]    acc_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_upd_q;

	logic                    m;
	logic                    fire;
	logic                    rise    [2];
	logic signed [CB-1:0]    cnt_nx  [2];
	logic [1:0]              dir_nx  [2];

	assign m           = cmd.motor;
	assign fire        = (tick_q == TW'(TICKS_PER_UPDATE - 1));
	assign st.fire     = fire;
	assign out_data    = out_data_q;
	assign out_updated = out_upd_q;

	// edge counting, both motors side by side
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			logic                 fast, up, bline;
			logic signed [CB:0]   sum;
			bline   = in_data[2*i+1];
			rise[i] = in_data[2*i] && !last_a_q[i];
			fast    = (speed_q[i] >= FAST_SPEED) || (speed_q[i] <= -FAST_SPEED);
			up      = fast ? 1'b1 : ((i == 0) ? bline : !bline);
			dir_nx[i] = (fast && speed_q[i][7]) ? DIR_NEG : DIR_POS;
			sum = {count_q[i][CB-1], count_q[i]} + (up ? (CB+1)'(1) : {(CB+1){1'b1}});
			// saturate at the signed count range
			if (sum[CB] != sum[CB-1])
				cnt_nx[i] = sum[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
			else
				cnt_nx[i] = sum[CB-1:0];
		end
	end

	// shared multiplier operand select
	logic signed [MA-1:0]    mul_a;
	logic signed [MB-1:0]    mul_b;
	logic [CB-1:0]           cnt_mag;
	logic signed [DER_W-1:0] der;

	assign cnt_mag = count_q[m][CB-1] ? CB'(-count_q[m]) : count_q[m];
	assign der     = {err_q[ERR_W-1], err_q} - {last_err_q[m][ERR_W-1], last_err_q[m]};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MAG: begin
				mul_a = (dir_q[m] == DIR_ZERO) ? '0 : {{(MA-CB){1'b0}}, cnt_mag};
				mul_b = SPEED_SCALE;
			end
			OP_MI: begin
				mul_a = {{(MA-ERR_W){err_q[ERR_W-1]}}, err_q};
				mul_b = {1'b0, period_q};
			end
			OP_MP: begin
				mul_a = {{(MA-ERR_W){err_q[ERR_W-1]}}, err_q};
				mul_b = {gain_p_q[15], gain_p_q};
			end
			OP_MG: begin
				mul_a = {{(MA-ACC_W){integ_q[m][ACC_W-1]}}, integ_q[m]};
				mul_b = {gain_i_q[15], gain_i_q};
			end
			OP_MD: begin
				mul_a = {{(MA-DER_W){der[DER_W-1]}}, der};
				mul_b = {gain_d_q[15], gain_d_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider setup and step
	logic [15:0]    div_eff;
	logic [CW-1:0]  div_top;
	logic [CW-1:0]  mag_ext;
	logic           ge;

	assign div_eff = (divisor_q == 16'd0) ? 16'd1 : divisor_q;
	assign div_top = CW'({div_eff, 7'b0});
	assign mag_ext = CW'(mul_q[MAGW-1:0]);
	assign ge      = (rem_q >= dsh_q);

	// speed, integral and drive results
	logic [6:0]               q7;
	logic signed [7:0]        spd_new;
	logic signed [26:0]       isum;
	logic signed [ACC_W-1:0]  integ_new;
	logic signed [ACC_W-1:0]  drive_new;
	logic signed [ERR_W-1:0]  err_new;

	assign q7      = ovf_q ? SPD_MAX : quo_q[6:0];
	assign spd_new = sgn_q ? -$signed({1'b0, q7}) : $signed({1'b0, q7});
	assign err_new = {tgt_q[m][7], tgt_q[m]} - {speed_q[m][7], speed_q[m]};
	assign isum    = {{3{integ_q[m][ACC_W-1]}}, integ_q[m]} + 27'(mul_q);

	always_comb begin
		if (isum[26:23] != {4{isum[26]}})
			integ_new = isum[26] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			integ_new = isum[ACC_W-1:0];
		if (err_q < ERR_FLOOR)
			drive_new = {{8{tgt_q[m][7]}}, tgt_q[m], 8'b0};
		else if (acc_q[AW-1:ACC_W-1] != {(AW-ACC_W+1){acc_q[AW-1]}})
			drive_new = acc_q[AW-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			drive_new = acc_q[ACC_W-1:0];
	end

	// command: truncate toward zero, clamp, scale to duty
	logic signed [16:0] cmd_int;
	logic signed [16:0] cmd_clp;
	logic [6:0]         cmd_mag;
	logic [20:0]        duty_prod;
	logic [7:0]         duty;
	logic               forward;

	always_comb begin
		cmd_int = {drive_q[m][ACC_W-1], drive_q[m][ACC_W-1:8]};
		if (drive_q[m][ACC_W-1] && (drive_q[m][7:0] != 8'd0)) cmd_int = cmd_int + 17'sd1;
		if (cmd_int > CMD_MAX) cmd_clp = CMD_MAX;
		else if (cmd_int < -CMD_MAX) cmd_clp = -CMD_MAX;
		else cmd_clp = cmd_int;
		cmd_mag   = cmd_clp[16] ? 7'(-cmd_clp) : cmd_clp[6:0];
		duty_prod = {14'd0, cmd_mag} * {7'd0, DUTY_MUL};
		duty      = duty_prod[DUTY_SHIFT+7:DUTY_SHIFT];
		forward   = !cmd_clp[16] && (cmd_clp != 17'sd0);
	end

	// configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= 16'sd26;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			divisor_q <= 16'd1;
			period_q  <= 16'd256;
			last_a_q  <= '0;
			tick_q    <= '0;
			for (int i = 0; i < 2; i++) begin
				count_q[i]    <= '0;
				dir_q[i]      <= DIR_ZERO;
				speed_q[i]    <= '0;
				last_err_q[i] <= '0;
				integ_q[i]    <= '0;
				drive_q[i]    <= '0;
				fwd_q[i]      <= '0;
				rev_q[i]      <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_GAIN_P:  gain_p_q  <= cfg_wdata;
					CFG_GAIN_I:  gain_i_q  <= cfg_wdata;
					CFG_GAIN_D:  gain_d_q  <= cfg_wdata;
					CFG_DIVISOR: divisor_q <= cfg_wdata;
					CFG_PERIOD:  period_q  <= cfg_wdata;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_ACCEPT: begin
					if (!in_kind) begin
						for (int i = 0; i < 2; i++) begin
							if (rise[i]) begin
								count_q[i] <= cnt_nx[i];
								dir_q[i]   <= dir_nx[i];
							end
							last_a_q[i] <= in_data[2*i];
						end
					end else begin
						tick_q <= fire ? '0 : tick_q + TW'(1);
					end
				end
				OP_SPD: begin
					speed_q[m] <= spd_new;
					count_q[m] <= '0;
				end
				OP_IA:  integ_q[m] <= integ_new;
				OP_DRV: begin
					drive_q[m]    <= drive_new;
					last_err_q[m] <= err_q;
				end
				OP_CMD: begin
					fwd_q[m] <= forward ? duty : 8'd0;
					rev_q[m] <= forward ? 8'd0 : duty;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				tgt_q[0] <= in_data[11:4];
				tgt_q[1] <= in_data[19:12];
				upd_q    <= in_kind && fire;
			end
			OP_MAG: begin
				mul_q <= mul_a * mul_b;
				sgn_q <= (dir_q[m] == DIR_NEG) ^ count_q[m][CB-1];
			end
			OP_CMP: begin
				rem_q <= mag_ext;
				dsh_q <= div_top;
				ovf_q <= (mag_ext >= div_top);
				quo_q <= '0;
			end
			OP_DIV: begin
				if (ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_BITS-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			OP_ERR: err_q <= err_new;
			OP_MI:  mul_q <= mul_a * mul_b;
			OP_MP: begin
				mul_q <= mul_a * mul_b;
				acc_q <= {{(AW-ACC_W){drive_q[m][ACC_W-1]}}, drive_q[m]};
			end
			OP_MG: begin
				mul_q <= mul_a * mul_b;
				acc_q <= acc_q + AW'(mul_q);
			end
			OP_MD: begin
				mul_q <= mul_a * mul_b;
				// floor of the integral term over 256
				acc_q <= acc_q + AW'(mul_q >>> 8);
			end
			OP_AD: acc_q <= acc_q + AW'(mul_q);
			OP_LOAD: begin
				out_data_q <= {speed_q[1], speed_q[0], fwd_q[1], rev_q[1], rev_q[0], fwd_q[0]};
				out_upd_q  <= upd_q;
			end
			default: ;
		endcase
	end

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q[0] != -8'sd128) && (speed_q[1] != -8'sd128))
		else $error("measured speed left the +-127 range");
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= TW'(TICKS_PER_UPDATE - 1))
		else $error("tick divider passed the update count");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SPD) |=> (count_q[$past(m)] == '0))
		else $error("edge count not cleared by the speed step");

endmodule

// ----- design/encoder_pid_motor_speed_control.sv -----
// Top level of the two-motor encoder PID speed controller.
//
// Input stream s_axis: each transfer is a pin sample (tuser = 0) that counts
// rising edges on each motor's A line, or a timer tick (tuser = 1). Every
// TICKS_PER_UPDATE ticks both motors run a control step: count to speed
// through the shared multiplier and an 8-step restoring divider, then the
// saturating Q16.8 PID update and the PWM duty mapping.
// Output stream m_axis: one transfer per input item, carrying the held duties
// and measured speeds, with tuser = 1 when that item ran the control step.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (gain_p,
// gain_i, gain_d, speed_divisor, integral_period); write only while idle.
// Sequence: a pin sample or a non-updating tick goes from the accept step straight
// to the done step; an updating tick first runs the step sequence for each motor,
// left then right, with sequential divide steps and one shared multiplier.
// The input side is ready again once the result sits in the output register,
// so one item may wait upstream of a stalled receiver; a stall holds the
// block in its done step until the result register frees up.
// Reset clears all counts, speeds, PID state and duties and restores the
// register defaults; no result is pending after reset.
module encoder_pid_motor_speed_control #(
	parameter int TICKS_PER_UPDATE = 4,
	parameter int COUNT_BITS       = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// left_enc_a, left_enc_b, right_enc_a, right_enc_b, target_left[7:0],
	// target_right[7:0], zero pad
	input  logic [epid_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// kind
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// left_pwm_a, left_pwm_b, right_pwm_a, right_pwm_b, left_speed, right_speed
	output logic [epid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// updated
	output logic [0:0]                          m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [epid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [epid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import epid_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    updated;

	assign m_axis_tuser = updated;

	epid_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_kind  (s_axis_tuser[0]),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	epid_dp #(
		.TICKS_PER_UPDATE (TICKS_PER_UPDATE),
		.COUNT_BITS       (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_data     (s_axis_tdata),
		.in_kind     (s_axis_tuser[0]),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.out_data    (m_axis_tdata),
		.out_updated (updated)
	);

endmodule

// ----- bench/encoder_pid_motor_speed_control_tb.sv -----
// Self-checking stream testbench for the two-motor encoder PID speed controller.
module encoder_pid_motor_speed_control_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import epid_pkg::*;

	localparam int     TICKS_PER_STEP = 4;
	localparam int     CNT_BITS       = 16;
	localparam longint CNT_HI         = (64'sd1 <<< (CNT_BITS - 1)) - 1;
	localparam longint CNT_LO         = -CNT_HI - 1;
	localparam longint ACC_HI         = 64'sd8388607;
	localparam longint ACC_LO         = -64'sd8388608;
	localparam int     STALL_LIMIT    = 1000;
	localparam int     DRAIN_CYCLES   = 50;
	localparam int     DIRECTED_ROWS  = 24;
	localparam int     PHASE_COUNT    = 5;
	localparam int     PHASE_ITEMS    = 264;
	localparam int     LONG_RUN_EDGES = 150;

	// item kinds carried in tuser
	localparam logic KIND_PIN  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic       l_a;
		logic       l_b;
		logic       r_a;
		logic       r_b;
		logic [7:0] tgt_l;
		logic [7:0] tgt_r;
	} sample_t;

	typedef struct packed {
		logic [7:0]        lpa;
		logic [7:0]        lpb;
		logic [7:0]        rpa;
		logic [7:0]        rpb;
		logic signed [7:0] lspd;
		logic signed [7:0] rspd;
		logic              upd;
	} drive_out_t;

	typedef struct packed {
		sample_t    smp;
		logic       fixed;
		drive_out_t want;
	} step_row_t;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [15:0] div;
		logic [15:0] per;
	} gain_set_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	encoder_pid_motor_speed_control #(
		.TICKS_PER_UPDATE(TICKS_PER_STEP),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// controller copy: gains, encoder and PID state
	logic signed [15:0]         g_p, g_i, g_d;
	logic [15:0]                spd_div, int_per;
	logic signed [CNT_BITS-1:0] edge_cnt [2];
	logic signed [1:0]          cnt_dir [2];
	logic                       prev_a [2];
	logic signed [7:0]          meas_spd [2];
	logic signed [8:0]          prev_err [2];
	logic signed [23:0]         err_acc [2];
	logic signed [23:0]         drive_acc [2];
	int                         tick_cnt;
	logic [7:0]                 duty [4];

	drive_out_t  duty_speed_q [$];
	int          mismatch_cnt;
	int          quiet_cycles;
	bit          quiet;
	logic        line_l, line_r;
	step_row_t   steps_table [0:DIRECTED_ROWS-1];
	gain_set_t   gain_sets [0:PHASE_COUNT-1];

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic reset_controller();
		g_p = 16'sd26;
		g_i = '0;
		g_d = '0;
		spd_div = 16'd1;
		int_per = 16'd256;
		for (int m = 0; m < 2; m++) begin
			edge_cnt[m] = '0;
			cnt_dir[m] = '0;
			prev_a[m] = 1'b0;
			meas_spd[m] = '0;
			prev_err[m] = '0;
			err_acc[m] = '0;
			drive_acc[m] = '0;
		end
		tick_cnt = 0;
		for (int k = 0; k < 4; k++) duty[k] = '0;
	endtask

	task automatic track_edge(input int m, input logic a, input logic b);
		longint sp;
		longint nxt;
		logic   up;
		if (a && !prev_a[m]) begin
			sp = longint'(meas_spd[m]);
			if (sp >= 15 || sp <= -15) begin
				cnt_dir[m] = (sp >= 0) ? 2'sd1 : -2'sd1;
				up = 1'b1;
			end else begin
				// slow: B line decides, polarity flipped on the right motor
				cnt_dir[m] = 2'sd1;
				up = (m == 0) ? b : !b;
			end
			nxt = clip(longint'(edge_cnt[m]) + (up ? 1 : -1), CNT_LO, CNT_HI);
			edge_cnt[m] = nxt[CNT_BITS-1:0];
		end
		prev_a[m] = a;
	endtask

	task automatic pid_step(input int m, input longint tgt);
		longint div, sp, err, acc, der, drv, cmd, mag, d;
		div = (spd_div == 16'd0) ? 64'sd1 : longint'(spd_div);
		sp = (64'sd6000 * longint'(cnt_dir[m]) * longint'(edge_cnt[m])) / div;
		sp = clip(sp, -127, 127);
		meas_spd[m] = sp[7:0];
		edge_cnt[m] = '0;
		err = tgt - sp;
		acc = clip(longint'(err_acc[m]) + err * longint'(int_per), ACC_LO, ACC_HI);
		err_acc[m] = acc[23:0];
		der = err - longint'(prev_err[m]);
		if (err < -10) begin
			drv = tgt * 256;
		end else begin
			// arithmetic shift floors the integral term
			drv = clip(longint'(drive_acc[m]) + longint'(g_p) * err
				+ ((longint'(g_i) * acc) >>> 8) + longint'(g_d) * der, ACC_LO, ACC_HI);
		end
		drive_acc[m] = drv[23:0];
		prev_err[m] = err[8:0];
		cmd = clip(drv / 256, -100, 100);
		mag = (cmd < 0) ? -cmd : cmd;
		d = mag * 255 / 100;
		if (m == 0) begin
			duty[0] = (cmd > 0) ? d[7:0] : 8'd0;
			duty[1] = (cmd > 0) ? 8'd0 : d[7:0];
		end else begin
			duty[2] = (cmd > 0) ? 8'd0 : d[7:0];
			duty[3] = (cmd > 0) ? d[7:0] : 8'd0;
		end
	endtask

	task automatic advance_controller(input sample_t s, output drive_out_t o);
		o.upd = 1'b0;
		if (s.kind == KIND_PIN) begin
			track_edge(0, s.l_a, s.l_b);
			track_edge(1, s.r_a, s.r_b);
		end else begin
			tick_cnt++;
			if (tick_cnt >= TICKS_PER_STEP) begin
				pid_step(0, longint'($signed(s.tgt_l)));
				pid_step(1, longint'($signed(s.tgt_r)));
				tick_cnt = 0;
				o.upd = 1'b1;
			end
		end
		o.lpa = duty[0];
		o.lpb = duty[1];
		o.rpa = duty[2];
		o.rpb = duty[3];
		o.lspd = meas_spd[0];
		o.rspd = meas_spd[1];
	endtask

	// drive one item and hold it until the transfer
	task automatic send_sample(input sample_t s, input bit fixed, input drive_out_t want);
		drive_out_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, s.tgt_r, s.tgt_l, s.r_b, s.r_a, s.l_b, s.l_a};
		s_axis_tuser <= s.kind;
		do @(posedge clk); while (!s_axis_tready);
		advance_controller(s, predicted);
		duty_speed_q.push_back(fixed ? want : predicted);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (duty_speed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		case (addr)
			CFG_GAIN_P:  g_p = val;
			CFG_GAIN_I:  g_i = val;
			CFG_GAIN_D:  g_d = val;
			CFG_DIVISOR: spd_div = val;
			CFG_PERIOD:  int_per = val;
			default: ;
		endcase
	endtask

	task automatic apply_gains(input gain_set_t c);
		write_reg(CFG_GAIN_P, c.kp);
		write_reg(CFG_GAIN_I, c.ki);
		write_reg(CFG_GAIN_D, c.kd);
		write_reg(CFG_DIVISOR, c.div);
		write_reg(CFG_PERIOD, c.per);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_target();
		int v;
		if ($urandom_range(0, 4) != 0) v = int'($urandom_range(0, 200)) - 100;
		else v = int'($urandom_range(0, 255)) - 128;
		return v[7:0];
	endfunction

	// mostly clean edge trains on A with ticks mixed in, plus some noise
	function automatic sample_t random_sample();
		sample_t s;
		int      r;
		r = $urandom_range(0, 99);
		s.tgt_l = random_target();
		s.tgt_r = random_target();
		if (r < 25) begin
			s.kind = KIND_TICK;
			{s.l_a, s.l_b, s.r_a, s.r_b} = 4'($urandom);
		end else if (r < 90) begin
			s.kind = KIND_PIN;
			s.l_a = ($urandom_range(0, 4) != 0) ? !line_l : line_l;
			s.r_a = ($urandom_range(0, 4) != 0) ? !line_r : line_r;
			s.l_b = 1'($urandom);
			s.r_b = 1'($urandom);
		end else begin
			s.kind = KIND_PIN;
			{s.l_a, s.l_b, s.r_a, s.r_b} = 4'($urandom);
		end
		if (s.kind == KIND_PIN) begin
			line_l = s.l_a;
			line_r = s.r_a;
		end
		return s;
	endfunction

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	task automatic take_result();
		drive_out_t want;
		drive_out_t got;
		got.lpa = m_axis_tdata[7:0];
		got.lpb = m_axis_tdata[15:8];
		got.rpa = m_axis_tdata[23:16];
		got.rpb = m_axis_tdata[31:24];
		got.lspd = m_axis_tdata[39:32];
		got.rspd = m_axis_tdata[47:40];
		got.upd = m_axis_tuser[0];
		if (duty_speed_q.size() == 0) begin
			mismatch_cnt++;
			$display("%0t: unexpected result, expected none, got %h/%b", $time,
				m_axis_tdata, m_axis_tuser);
		end else begin
			want = duty_speed_q.pop_front();
			compare_field("left_pwm_a", want.lpa, got.lpa);
			compare_field("left_pwm_b", want.lpb, got.lpb);
			compare_field("right_pwm_a", want.rpa, got.rpa);
			compare_field("right_pwm_b", want.rpb, got.rpb);
			compare_field("left_speed", want.lspd, got.lspd);
			compare_field("right_speed", want.rspd, got.rspd);
			compare_field("updated", want.upd, got.upd);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: check each transfer, stall in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) take_result();
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		sample_t s;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		quiet = 1'b0;
		line_l = 1'b0;
		line_r = 1'b0;
		reset_controller();

		// kind, lA, lB, rA, rB, target left, target right; fixed flag; result
		steps_table = '{
			'{'{KIND_PIN, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b1,
				'{8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0}},
			// lines on a tick are ignored
			'{'{KIND_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 8'sd100, -8'sd100}, 1'b1,
				'{8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0}},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd100, -8'sd100}, 1'b1,
				'{8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0}},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd100, -8'sd100}, 1'b1,
				'{8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0}},
			// left: P term only; right: large negative error loads the target
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd100, -8'sd100}, 1'b1,
				'{8'd25, 8'd0, 8'd255, 8'd0, 8'sd0, 8'sd0, 1'b1}},
			'{'{KIND_PIN, 1'b1, 1'b1, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b1, 1'b0, 1'b1, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b1, 1'b0, 1'b1, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b0, 1'b1, 1'b0, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b1, 1'b1, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd127, 8'h80}, 1'b0, '0},
			'{'{KIND_PIN, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b1, 1'b0, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_PIN, 1'b1, 1'b1, 1'b1, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
			'{'{KIND_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 8'h80, 8'sd127}, 1'b0, '0},
			'{'{KIND_PIN, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0}
		};

		// kp, ki, kd, divisor, integral period
		gain_sets = '{
			'{16'd256, 16'd16, 16'd64, 16'd400, 16'd256},
			'{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff},
			'{16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0},
			'{16'd0, 16'd0, 16'd0, 16'd1, 16'd0},
			'{16'd40, 16'd4, -16'sd20, 16'd429, 16'd128}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_sample(steps_table[i].smp, steps_table[i].fixed, steps_table[i].want);

		// long edge trains on both motors, then convert
		quiet = 1'b1;
		for (int i = 0; i < 2 * LONG_RUN_EDGES; i++) begin
			s = '{KIND_PIN, 1'(i % 2 == 0), 1'b1, 1'(i % 2 == 0), 1'b1, 8'sd0, 8'sd0};
			send_sample(s, 1'b0, '0);
		end
		for (int i = 0; i < TICKS_PER_STEP; i++) begin
			s = '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd50, -8'sd50};
			send_sample(s, 1'b0, '0);
		end
		quiet = 1'b0;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			if (p == 3)
				gain_sets[p] = '{16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(1, 3000)), 16'($urandom_range(0, 1024))};
			apply_gains(gain_sets[p]);
			quiet = (p == PHASE_COUNT - 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_sample(random_sample(), 1'b0, '0);
		end

		drain_results();
		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
